// ===== src/gqie_pkg.sv =====
`timescale 1ns / 1ps

package gqie_pkg;

	localparam int SEG_W          = 4;
	localparam int STEP_W         = 17;
	localparam int IDX_W          = 7;
	localparam int TEX_W          = 17;
	localparam int CORNER_W       = 3;
	localparam int CORNERS        = 6;
	localparam int MAX_SEGMENTS_D = 10;
	localparam int APB_AW         = 5;
	localparam int APB_DW         = 32;
	localparam int S_DATA_W       = 8;
	localparam int M_DATA_W       = 48;

	localparam logic [TEX_W-1:0]    Q16_ONE     = TEX_W'(65536);
	localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(CORNERS - 1);

	typedef enum logic [2:0] {
		REG_COLUMN_SEGMENTS = 3'd0,
		REG_ROW_SEGMENTS    = 3'd1,
		REG_WINDING_SWAP    = 3'd2,
		REG_U_STEP          = 3'd3,
		REG_V_STEP          = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [SEG_W-1:0]  column_segments;
		logic [SEG_W-1:0]  row_segments;
		logic              winding_swap;
		logic [STEP_W-1:0] u_step;
		logic [STEP_W-1:0] v_step;
	} cfg_t;

	// One quad in flight: its position, the clamped column count and winding.
	typedef struct packed {
		logic [SEG_W-1:0] col;
		logic [SEG_W-1:0] row;
		logic [SEG_W-1:0] cols;
		logic             flip;
		logic             final_quad;
	} quad_t;

	// Column and row offset {dc, dr} of each corner within the quad.
	function automatic logic [1:0] corner_offset(input logic [CORNER_W-1:0] k,
		input logic flip);
		logic [1:0] off;
		off = 2'b00;
		if (flip) begin
			case (k)
				3'd0: off = 2'b00;
				3'd1: off = 2'b10;
				3'd2: off = 2'b01;
				3'd3: off = 2'b10;
				3'd4: off = 2'b11;
				3'd5: off = 2'b01;
				default: off = 2'b00;
			endcase
		end else begin
			case (k)
				3'd0: off = 2'b00;
				3'd1: off = 2'b01;
				3'd2: off = 2'b10;
				3'd3: off = 2'b10;
				3'd4: off = 2'b01;
				3'd5: off = 2'b11;
				default: off = 2'b00;
			endcase
		end
		return off;
	endfunction

endpackage

// ===== src/grid_quad_index_emitter.sv =====
`timescale 1ns / 1ps

// Grid quad index emitter: tessellates a flat grid into triangles, one quad per input beat.
//
// Channels:
//   s_*   input beats; s_tdata[0] = restart (go back to the first quad first).
//   m_*   corner beats, six per input beat; m_tdata holds vertex index, tex u, tex v;
//         m_tlast marks the sixth corner of a quad, m_tuser the sixth corner of the
//         last quad of the mesh.
//   APB   five configuration registers at byte addresses 0,4,8,12,16; write them only
//         while no corners are pending.
// Order: an input beat is taken into the item register, and its first corner then moves into
// the output register; the remaining five follow one per cycle while m_tready is not low.
// Throughput: one input beat per quad, set by the single result channel that carries one
// corner per cycle when not stalled. The next input beat is taken in the same cycle the
// sixth corner is loaded, so beats flow with no gap.
// Reset: registers return to 1x1 grid, normal winding, unit steps; position to quad 0.
// Stall: when m_tready is low the output register holds its corner, the corner
// sequencer holds, and s_tready stays low until the quad's last corner is loaded.
module grid_quad_index_emitter
	import gqie_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_D
) (
	input  logic                clk,
	input  logic                arst_n,
	// APB configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	// input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // [0] restart, [7:1] zero
	// corner stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // [6:0] vertex_index, [23:7] tex_u,
	                                       // [40:24] tex_v, [47:41] zero
	output logic                m_tlast,   // quad_done
	output logic                m_tuser    // mesh_done
);

	localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_SEGMENTS);

	cfg_t                cfg;
	logic [SEG_W-1:0]    cols;
	logic [SEG_W-1:0]    rows;
	logic [SEG_W-1:0]    quad_column_q;
	logic [SEG_W-1:0]    quad_row_q;
	logic                restart;
	logic                beyond;
	logic [SEG_W-1:0]    cur_col;
	logic [SEG_W-1:0]    cur_row;
	logic [SEG_W-1:0]    col_inc;
	logic [SEG_W-1:0]    row_inc;
	logic                row_end;
	logic                col_end;
	logic                accept;
	logic                load_out;
	logic                last_corner;

	quad_t               quad_s1;
	logic                valid_s1;
	logic [CORNER_W-1:0] corner_s1;

	logic [IDX_W-1:0]    c_index;
	logic [TEX_W-1:0]    c_u;
	logic [TEX_W-1:0]    c_v;
	logic                c_quad_done;
	logic                c_mesh_done;

	gqie_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Clamp segment counts to 1..MAX_SEGMENTS.
	assign cols = (cfg.column_segments == '0) ? SEG_W'(1) :
	              (cfg.column_segments > SEG_MAX) ? SEG_MAX : cfg.column_segments;
	assign rows = (cfg.row_segments == '0) ? SEG_W'(1) :
	              (cfg.row_segments > SEG_MAX) ? SEG_MAX : cfg.row_segments;

	// Quad position for this beat; start over on restart or if the grid shrank.
	assign restart = s_tdata[0];
	assign beyond  = restart || (quad_column_q >= cols) || (quad_row_q >= rows);
	assign cur_col = beyond ? '0 : quad_column_q;
	assign cur_row = beyond ? '0 : quad_row_q;
	assign col_inc = cur_col + SEG_W'(1);
	assign row_inc = cur_row + SEG_W'(1);
	assign col_end = (col_inc >= cols);
	assign row_end = (row_inc >= rows);

	// Handshake: the item register frees as its sixth corner moves to the output.
	assign last_corner = (corner_s1 == LAST_CORNER);
	assign load_out    = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready    = !valid_s1 || (load_out && last_corner);
	assign accept      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_column_q <= '0;
			quad_row_q    <= '0;
			valid_s1      <= 1'b0;
			corner_s1     <= '0;
		end else begin
			if (accept) begin
				// Advance in row-major order, wrapping after the final quad.
				quad_column_q <= col_end ? '0 : col_inc;
				quad_row_q    <= col_end ? (row_end ? '0 : row_inc) : cur_row;
				valid_s1      <= 1'b1;
				corner_s1     <= '0;
			end else if (load_out) begin
				if (last_corner) begin
					valid_s1 <= 1'b0;
				end else begin
					corner_s1 <= corner_s1 + CORNER_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			quad_s1.col        <= cur_col;
			quad_s1.row        <= cur_row;
			quad_s1.cols       <= cols;
			quad_s1.flip       <= cfg.winding_swap;
			quad_s1.final_quad <= col_end && row_end && (col_inc == cols) && (row_inc == rows);
		end
	end

	gqie_corner u_corner (
		.quad         (quad_s1),
		.k            (corner_s1),
		.u_step       (cfg.u_step),
		.v_step       (cfg.v_step),
		.vertex_index (c_index),
		.tex_u        (c_u),
		.tex_v        (c_v),
		.quad_done    (c_quad_done),
		.mesh_done    (c_mesh_done)
	);

	// Output register: load a corner whenever the slot is empty or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load_out) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata <= {(M_DATA_W - IDX_W - 2 * TEX_W)'(0), c_v, c_u, c_index};
			m_tlast <= c_quad_done;
			m_tuser <= c_mesh_done;
		end
	end

endmodule

// ===== src/gqie_regs.sv =====
`timescale 1ns / 1ps

module gqie_regs
	import gqie_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [2:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[APB_AW-1:2];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.column_segments <= SEG_W'(1);
			cfg.row_segments    <= SEG_W'(1);
			cfg.winding_swap    <= 1'b0;
			cfg.u_step          <= STEP_W'(65536);
			cfg.v_step          <= STEP_W'(65536);
		end else if (wr) begin
			case (idx)
				REG_COLUMN_SEGMENTS: cfg.column_segments <= pwdata[SEG_W-1:0];
				REG_ROW_SEGMENTS:    cfg.row_segments    <= pwdata[SEG_W-1:0];
				REG_WINDING_SWAP:    cfg.winding_swap    <= pwdata[0];
				REG_U_STEP:          cfg.u_step          <= pwdata[STEP_W-1:0];
				REG_V_STEP:          cfg.v_step          <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_COLUMN_SEGMENTS: prdata = APB_DW'(cfg.column_segments);
			REG_ROW_SEGMENTS:    prdata = APB_DW'(cfg.row_segments);
			REG_WINDING_SWAP:    prdata = APB_DW'(cfg.winding_swap);
			REG_U_STEP:          prdata = APB_DW'(cfg.u_step);
			REG_V_STEP:          prdata = APB_DW'(cfg.v_step);
			default:             prdata = '0;
		endcase
	end

endmodule

// ===== src/gqie_corner.sv =====
`timescale 1ns / 1ps

module gqie_corner
	import gqie_pkg::*;
(
	input  quad_t               quad,
	input  logic [CORNER_W-1:0] k,
	input  logic [STEP_W-1:0]   u_step,
	input  logic [STEP_W-1:0]   v_step,
	output logic [IDX_W-1:0]    vertex_index,
	output logic [TEX_W-1:0]    tex_u,
	output logic [TEX_W-1:0]    tex_v,
	output logic                quad_done,
	output logic                mesh_done
);

	localparam int IDX_FULL_W = 2 * SEG_W + 1;
	localparam int PROD_W     = SEG_W + STEP_W;

	logic [1:0]            off;
	logic [SEG_W-1:0]      col;
	logic [SEG_W-1:0]      row;
	logic [SEG_W:0]        cols_p1;
	logic [IDX_FULL_W-1:0] idx_full;
	logic [PROD_W-1:0]     u_full;
	logic [PROD_W-1:0]     dv;

	assign off     = corner_offset(k, quad.flip);
	assign col     = quad.col + SEG_W'(off[1]);
	assign row     = quad.row + SEG_W'(off[0]);
	assign cols_p1 = {1'b0, quad.cols} + (SEG_W+1)'(1);

	assign idx_full = IDX_FULL_W'(row) * IDX_FULL_W'(cols_p1) + IDX_FULL_W'(col);
	assign u_full   = PROD_W'(col) * PROD_W'(u_step);
	assign dv       = PROD_W'(row) * PROD_W'(v_step);

	// Saturate u at 1.0, floor v at zero.
	assign vertex_index = idx_full[IDX_W-1:0];
	assign tex_u = (u_full > PROD_W'(Q16_ONE)) ? Q16_ONE : u_full[TEX_W-1:0];
	assign tex_v = (dv >= PROD_W'(Q16_ONE)) ? '0 : (Q16_ONE - dv[TEX_W-1:0]);

	assign quad_done = (k == LAST_CORNER);
	assign mesh_done = quad_done && quad.final_quad;

endmodule

// ===== src/gqie_checker.sv =====
`timescale 1ns / 1ps

module gqie_checker
	import gqie_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tlast,
	input logic                m_tuser
);

	logic [CORNER_W-1:0] beat_q;
	logic [CORNER_W:0]   pending_q;
	logic                s_beat;
	logic                m_beat;

	assign s_beat = s_tvalid && s_tready;
	assign m_beat = m_tvalid && m_tready;

	// Count corner beats within the current quad.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= '0;
		end else if (m_beat) begin
			beat_q <= (beat_q == LAST_CORNER) ? '0 : beat_q + CORNER_W'(1);
		end
	end

	// Quads taken whose last corner has not yet left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + (CORNER_W+1)'(s_beat) - (CORNER_W+1)'(m_beat && m_tlast);
		end
	end

	a_last_on_sixth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (beat_q == LAST_CORNER)))
		else $error("tlast not on sixth corner");

	a_mesh_implies_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("mesh done without quad done");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[23:7] <= Q16_ONE) && (m_tdata[40:24] <= Q16_ONE)))
		else $error("texture coordinate beyond 1.0");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= (CORNER_W+1)'(2))
		else $error("more than two quads in flight");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("corner changed while stalled");

endmodule

bind grid_quad_index_emitter gqie_checker u_gqie_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
